>>> rtl/mh64b_pkg.sv
// mh64b_pkg: shared types and constants of the murmur64b_hash64 block
// used by the front, queue, back and top level; depends on nothing
package mh64b_pkg;

    localparam logic [31:0] MIX_MUL     = 32'h5bd1e995;
    localparam int unsigned MIX_SHIFT   = 24;
    localparam int unsigned FIN_SHIFT_0 = 18;
    localparam int unsigned FIN_SHIFT_1 = 22;
    localparam int unsigned FIN_SHIFT_2 = 17;
    localparam int unsigned FIN_SHIFT_3 = 19;
    localparam logic [31:0] SEED_RESET  = 32'h7fffffff;

    localparam int unsigned IN_TDATA_W  = 72;
    localparam int unsigned OUT_TDATA_W = 64;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_EMPTY = 1'b1;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_FOLD,
        OP_TAIL,
        OP_EMPTY
    } op_kind_t;

    typedef struct packed {
        op_kind_t    kind;
        logic        restart;
        logic        last;
        logic [31:0] word;
        logic [31:0] init;
    } op_t;

endpackage

>>> rtl/mh64b_front.sv
// mh64b_front: input word classification and seed register
// depends on mh64b_pkg
module mh64b_front (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [mh64b_pkg::IN_TDATA_W-1:0]       s_tdata,
    input  logic                                   s_tlast,
    input  logic                                   s_tuser,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [31:0]                            cfg_data,
    output logic                                   push_valid,
    input  logic                                   push_ready,
    output mh64b_pkg::op_t                         push_op
);
    import mh64b_pkg::*;

    logic [31:0] seed_reg;
    logic [31:0] seed_next;
    logic [31:0] word;
    logic [2:0]  count;
    logic [31:0] klen;
    logic [31:0] mask;
    op_kind_t    kind;

    assign word  = s_tdata[31:0];
    assign count = s_tdata[34:32];
    assign klen  = s_tdata[66:35];

    assign cfg_ready = 1'b1;
    assign seed_next = cfg_valid ? cfg_data : seed_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= SEED_RESET;
        end
        else
        begin
            seed_reg <= seed_next;
        end
    end

    always_comb
    begin
        case (count)
            3'd1:    mask = 32'h000000ff;
            3'd2:    mask = 32'h0000ffff;
            3'd3:    mask = 32'h00ffffff;
            default: mask = 32'hffffffff;
        endcase
    end

    always_comb
    begin
        if (s_tuser && (klen == 32'd0))
        begin
            kind = OP_EMPTY;
        end
        else if (count[2])
        begin
            kind = OP_FOLD;
        end
        else if (s_tlast && (count != 3'd0))
        begin
            kind = OP_TAIL;
        end
        else
        begin
            kind = OP_NONE;
        end
    end

    assign push_op.kind    = kind;
    assign push_op.restart = s_tuser;
    assign push_op.last    = s_tlast;
    assign push_op.word    = (kind == OP_TAIL) ? (word & mask) : word;
    assign push_op.init    = klen ^ seed_reg;

    assign push_valid = s_tvalid;
    assign s_tready   = push_ready;

endmodule

>>> rtl/mh64b_queue.sv
// mh64b_queue: short queue of classified words between front and back
// depends on mh64b_pkg
module mh64b_queue #(
    parameter int DEPTH = 2
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  mh64b_pkg::op_t push_op,
    output logic           pop_valid,
    input  logic           pop_ready,
    output mh64b_pkg::op_t pop_op
);
    import mh64b_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    op_t              mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_op     = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

>>> rtl/mh64b_back.sv
// mh64b_back: lane state, shared multiplier sequencer and output register
// depends on mh64b_pkg
module mh64b_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                pop_valid,
    output logic                                pop_ready,
    input  mh64b_pkg::op_t                      pop_op,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [mh64b_pkg::OUT_TDATA_W-1:0]   m_tdata,
    output logic                                m_tuser
);
    import mh64b_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FOLD_A,
        ST_FOLD_B,
        ST_FOLD_C,
        ST_TAIL,
        ST_LOAD,
        ST_MIX,
        ST_EMIT
    } state_t;

    state_t      state_reg, state_next;
    op_t         op_reg, op_next;
    logic [31:0] lane1_reg, lane1_next;
    logic [31:0] lane2_reg, lane2_next;
    logic        odd_reg, odd_next;
    logic [31:0] t_reg, t_next;
    logic [31:0] h1_reg, h1_next;
    logic [31:0] h2_reg, h2_next;
    logic [1:0]  step_reg, step_next;
    logic        status_reg, status_next;
    logic        m_valid_reg, m_valid_next;
    logic [63:0] m_data_reg, m_data_next;
    logic        m_user_reg, m_user_next;
    logic [31:0] mul_in;
    logic [31:0] product;

    // shared 32x32 multiplier, low word only
    always_comb
    begin
        case (state_reg)
            ST_FOLD_A: mul_in = op_reg.word;
            ST_FOLD_B: mul_in = t_reg ^ (t_reg >> MIX_SHIFT);
            ST_FOLD_C: mul_in = odd_reg ? lane2_reg : lane1_reg;
            ST_TAIL:   mul_in = lane2_reg ^ op_reg.word;
            ST_MIX:
            begin
                case (step_reg)
                    2'd0:    mul_in = h1_reg ^ (h2_reg >> FIN_SHIFT_0);
                    2'd1:    mul_in = h2_reg ^ (h1_reg >> FIN_SHIFT_1);
                    2'd2:    mul_in = h1_reg ^ (h2_reg >> FIN_SHIFT_2);
                    default: mul_in = h2_reg ^ (h1_reg >> FIN_SHIFT_3);
                endcase
            end
            default:   mul_in = '0;
        endcase
    end

    assign product = 32'(mul_in * MIX_MUL);

    assign pop_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        lane1_next   = lane1_reg;
        lane2_next   = lane2_reg;
        odd_next     = odd_reg;
        t_next       = t_reg;
        h1_next      = h1_reg;
        h2_next      = h2_reg;
        step_next    = step_reg;
        status_next  = status_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;

        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (pop_valid)
                begin
                    op_next = pop_op;
                    if (pop_op.kind == OP_EMPTY)
                    begin
                        h1_next     = '0;
                        h2_next     = '0;
                        status_next = STATUS_EMPTY;
                        state_next  = ST_EMIT;
                    end
                    else
                    begin
                        status_next = STATUS_OK;
                        if (pop_op.restart)
                        begin
                            lane1_next = pop_op.init;
                            lane2_next = '0;
                            odd_next   = 1'b0;
                        end
                        case (pop_op.kind)
                            OP_FOLD: state_next = ST_FOLD_A;
                            OP_TAIL: state_next = ST_TAIL;
                            default: state_next = pop_op.last ? ST_LOAD : ST_IDLE;
                        endcase
                    end
                end
            end
            ST_FOLD_A:
            begin
                t_next     = product;
                state_next = ST_FOLD_B;
            end
            ST_FOLD_B:
            begin
                t_next     = product;
                state_next = ST_FOLD_C;
            end
            ST_FOLD_C:
            begin
                if (odd_reg)
                begin
                    lane2_next = product ^ t_reg;
                end
                else
                begin
                    lane1_next = product ^ t_reg;
                end
                odd_next   = ~odd_reg;
                state_next = op_reg.last ? ST_LOAD : ST_IDLE;
            end
            ST_TAIL:
            begin
                lane2_next = product;
                state_next = op_reg.last ? ST_LOAD : ST_IDLE;
            end
            ST_LOAD:
            begin
                h1_next    = lane1_reg;
                h2_next    = lane2_reg;
                step_next  = '0;
                state_next = ST_MIX;
            end
            ST_MIX:
            begin
                if (step_reg[0])
                begin
                    h2_next = product;
                end
                else
                begin
                    h1_next = product;
                end
                step_next = step_reg + 1'b1;
                if (step_reg == 2'd3)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {h1_reg, h2_reg};
                    m_user_next  = status_reg;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            op_reg      <= '0;
            lane1_reg   <= '0;
            lane2_reg   <= '0;
            odd_reg     <= 1'b0;
            t_reg       <= '0;
            h1_reg      <= '0;
            h2_reg      <= '0;
            step_reg    <= '0;
            status_reg  <= STATUS_OK;
            m_valid_reg <= 1'b0;
            m_data_reg  <= '0;
            m_user_reg  <= STATUS_OK;
        end
        else
        begin
            state_reg   <= state_next;
            op_reg      <= op_next;
            lane1_reg   <= lane1_next;
            lane2_reg   <= lane2_next;
            odd_reg     <= odd_next;
            t_reg       <= t_next;
            h1_reg      <= h1_next;
            h2_reg      <= h2_next;
            step_reg    <= step_next;
            status_reg  <= status_next;
            m_valid_reg <= m_valid_next;
            m_data_reg  <= m_data_next;
            m_user_reg  <= m_user_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

>>> rtl/murmur64b_hash64_core.sv
// murmur64b_hash64_core: streaming 64-bit murmur hash (two 32-bit lanes)
// depends on mh64b_pkg, mh64b_front, mh64b_queue, mh64b_back
//
// usage
//  - s_* carries key words: tdata = data_word, byte_count, key_length;
//    tuser = first word of a key, tlast = last word of a key
//  - m_* carries one result per key: tdata = hash, tuser = status
//    (1 when a first word has key length zero, hash then zero)
//  - cfg_* writes the seed; take it only while the block is idle
//  - front classifies each word and pushes it into a queue of
//    QUEUE_DEPTH entries; back runs one shared 32x32 multiplier
//  - back steps per word: full word pop + three multiplies, short tail
//    word pop + one multiply, other words pop only; back pops the next
//    word only once it is idle again
//  - a last word adds lane copy, four mix multiplies and output load
//  - an empty key goes from the queue straight to the output load
//  - reset clears the lanes and the queue and sets the seed to 0x7fffffff
//  - a stalled m_tready holds the result; back keeps working until its
//    next result, then s_tready drops once the queue is full
module murmur64b_hash64_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // data_word[31:0], byte_count[34:32], key_length[66:35], zero pad
    input  logic [mh64b_pkg::IN_TDATA_W-1:0]    s_tdata,
    input  logic                                s_tlast,
    // first_item
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // hash_value[63:0]
    output logic [mh64b_pkg::OUT_TDATA_W-1:0]   m_tdata,
    // status
    output logic                                m_tuser,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [31:0]                         cfg_data
);
    import mh64b_pkg::*;

    op_t  push_op;
    op_t  pop_op;
    logic push_valid;
    logic push_ready;
    logic pop_valid;
    logic pop_ready;

    mh64b_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .s_tuser    (s_tuser),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_op    (push_op)
    );

    mh64b_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_op    (push_op),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_op     (pop_op)
    );

    mh64b_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_op    (pop_op),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

>>> rtl/mh64b_checker.sv
// mh64b_checker: port-level assertions for murmur64b_hash64_core
// depends on mh64b_pkg; bound to the top level below
module mh64b_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic [mh64b_pkg::IN_TDATA_W-1:0]    s_tdata,
    input logic                                s_tlast,
    input logic                                s_tuser,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [mh64b_pkg::OUT_TDATA_W-1:0]   m_tdata,
    input logic                                m_tuser,
    input logic                                cfg_valid,
    input logic                                cfg_ready,
    input logic [31:0]                         cfg_data
);
    import mh64b_pkg::*;

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result word dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == STATUS_EMPTY) |-> (m_tdata == '0))
        else $error("empty key result carries a nonzero hash");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("seed write not taken");

endmodule

bind murmur64b_hash64_core mh64b_checker u_checker (.*);
